[rtl/lda_gibbs_topic_sampler_defines.svh]
// assertion macros used by the topic sampler rtl
`ifndef LDA_GIBBS_TOPIC_SAMPLER_DEFINES_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LGTS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgts: assertion failed");

// next-cycle implication, checked outside reset
`define LGTS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgts: assertion failed");

`endif

[rtl/lgts_pkg.sv]
// shared types and constants of the topic sampler
package lgts_pkg;

   localparam int TOPICS   = 16;
   localparam int WORDS    = 1024;
   localparam int DOCS     = 256;
   localparam int TOKENS   = 32768;

   localparam int TOPIC_W  = 4;
   localparam int WORD_W   = 10;
   localparam int DOC_W    = 8;
   localparam int TOKEN_W  = 15;
   localparam int CNT_W    = 16;
   localparam int PRIOR_W  = 16;
   localparam int WIU_W    = 11;
   localparam int TIU_W    = 5;
   localparam int RAND_W   = 16;
   localparam int WEIGHT_W = 32;
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   localparam int WT_DEPTH = WORDS * TOPICS;
   localparam int DT_DEPTH = DOCS * TOPICS;

   localparam logic [PRIOR_W-1:0] ALPHA_RST = 16'd4096;
   localparam logic [PRIOR_W-1:0] BETA_RST  = 16'd410;
   localparam logic [WIU_W-1:0]   WIU_RST   = 11'd1024;
   localparam logic [TIU_W-1:0]   TIU_RST   = 5'd16;

   typedef enum logic [1:0] {
      FUNC_LOAD,
      FUNC_RESAMPLE,
      FUNC_READ,
      FUNC_NONE
   } func_type;

   typedef enum logic [1:0] {
      REG_ALPHA,
      REG_BETA,
      REG_WIU,
      REG_TIU
   } reg_type;

   typedef struct packed {
      func_type            func;
      logic [WORD_W-1:0]   word;
      logic [DOC_W-1:0]    doc;
      logic [TOKEN_W-1:0]  token;
      logic [TOPIC_W-1:0]  topic;
      logic [RAND_W-1:0]   rand_scale;
      logic [RAND_W-1:0]   rand_start;
   } req_type;

   typedef struct packed {
      logic [TOPIC_W-1:0] new_topic;
      logic [CNT_W-1:0]   word_topic_count;
      logic [CNT_W-1:0]   doc_topic_count;
      logic [CNT_W-1:0]   topic_total;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic sel_load_in;
      logic sel_load_tok;
      logic sel_zero;
      logic sel_inc;
      logic sel_reduce;
      logic dec_write;
      logic inc_write;
      logic out_read;
      logic out_zero;
      logic mul;
      logic div_start;
      logic div_step;
      logic wt_store;
      logic walk_init;
      logic walk_step;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     clr_last;
      logic     sel_ge_t;
      logic     sel_last;
      logic     div_last;
      logic     walk_go;
   } sts_type;

endpackage

[rtl/lda_gibbs_topic_sampler.sv]
// topic sampler top level: register port, result register, sequencer and datapath
// Collapsed Gibbs sampler for topic counts. One beat on req carries a load, a
// resample, a read or an unused function code, and yields exactly one beat on
// rsp. After reset the block zeroes its word-topic and doc-topic count memories,
// one entry a cycle over WORDS*TOPICS = 16384 entries, and takes no beat until
// that sweep is done; register writes are taken throughout. Items run one at a
// time. A load reduces the topic modulo the active topic count. A resample runs
// the one-bit-per-cycle weight divider once for each of T active topics, then
// walks the topics in at most 2*T+1 steps. The rsp register lets the next beat
// be taken while a result waits.
module lda_gibbs_topic_sampler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lgts_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lgts_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lgts_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [lgts_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [lgts_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import lgts_pkg::*;

   logic [PRIOR_W-1:0] alpha_ff, beta_ff;
   logic [WIU_W-1:0]   wiu_ff;
   logic [TIU_W-1:0]   tiu_ff;
   logic [TIU_W-1:0]   topics_act;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               csr_wr;
   reg_type            csr_idx;
   logic               idle, req_fire, out_free, load_rsp;
   cmd_type            cmd;
   sts_type            sts;
   rsp_type            result;

   assign csr_wr  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RST;
         beta_ff  <= BETA_RST;
         wiu_ff   <= WIU_RST;
         tiu_ff   <= TIU_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ALPHA: alpha_ff <= csr_pwdata[PRIOR_W-1:0];
            REG_BETA:  beta_ff  <= csr_pwdata[PRIOR_W-1:0];
            REG_WIU:   wiu_ff   <= csr_pwdata[WIU_W-1:0];
            REG_TIU:   tiu_ff   <= csr_pwdata[TIU_W-1:0];
            default:   tiu_ff   <= tiu_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ALPHA: csr_prdata = PDATA_W'(alpha_ff);
         REG_BETA:  csr_prdata = PDATA_W'(beta_ff);
         REG_WIU:   csr_prdata = PDATA_W'(wiu_ff);
         REG_TIU:   csr_prdata = PDATA_W'(tiu_ff);
         default:   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // zero topics count as one, more than built count as all
   assign topics_act = (tiu_ff == '0) ? TIU_W'(1) :
                       (tiu_ff > TIU_W'(TOPICS)) ? TIU_W'(TOPICS) : tiu_ff;

   assign req_ready = idle;
   assign req_fire  = req_valid & idle;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lgts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .sts      (sts),
      .idle     (idle),
      .load_rsp (load_rsp),
      .cmd      (cmd)
   );

   lgts_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .alpha        (alpha_ff),
      .beta         (beta_ff),
      .words_in_use (wiu_ff),
      .topics_act   (topics_act),
      .cmd          (cmd),
      .sts          (sts),
      .result       (result)
   );

endmodule

[rtl/lgts_ram.sv]
// generic single-write, single-read ram with registered read data
module lgts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lgts_dp.sv]
// sampler datapath: count memories, weight multiplier, serial divider, topic walk
module lgts_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  lgts_pkg::req_type             req_data,
   input  logic [lgts_pkg::PRIOR_W-1:0]  alpha,
   input  logic [lgts_pkg::PRIOR_W-1:0]  beta,
   input  logic [lgts_pkg::WIU_W-1:0]    words_in_use,
   input  logic [lgts_pkg::TIU_W-1:0]    topics_act,
   input  lgts_pkg::cmd_type             cmd,
   output lgts_pkg::sts_type             sts,
   output lgts_pkg::rsp_type             result
);
   import lgts_pkg::*;

   localparam int WT_AW  = $clog2(WT_DEPTH);
   localparam int DT_AW  = $clog2(DT_DEPTH);
   localparam int TK_AW  = $clog2(TOKENS);
   localparam int FAC_W  = CNT_W + 12 + 1;
   localparam int PROD_W = 2 * FAC_W;
   localparam int WB_W   = PRIOR_W + WIU_W;
   localparam int DEN_W  = FAC_W;
   localparam int RDV_W  = DEN_W + 1;
   localparam int BIT_W  = $clog2(WEIGHT_W);
   localparam int RP_W   = RAND_W + 1 + WEIGHT_W;
   localparam int REM_W  = RP_W - RAND_W + 2;
   localparam int SP_W   = RAND_W + TIU_W;
   localparam int STEP_W = TIU_W + 1;

   req_type                 item_ff;
   logic [TOPIC_W-1:0]      sel_ff;
   logic [WT_AW-1:0]        clr_ff;
   logic [WB_W-1:0]         wb_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [RDV_W-1:0]        rdiv_ff;
   logic [WEIGHT_W-1:0]     numlo_ff;
   logic [WEIGHT_W-1:0]     quot_ff;
   logic                    sat_ff;
   logic [BIT_W-1:0]        bit_ff;
   logic [WEIGHT_W-1:0]     wts_ff [TOPICS];
   logic [WEIGHT_W-1:0]     maxw_ff;
   logic signed [REM_W-1:0] rem_ff;
   logic [STEP_W-1:0]       steps_ff;
   logic [CNT_W-1:0]        totals_ff [TOPICS];
   rsp_type                 result_ff;

   logic [CNT_W-1:0]        wt_rd, dt_rd;
   logic [TOPIC_W-1:0]      tk_rd;
   logic [TIU_W-1:0]        sel_plus;
   logic                    sel_last, sel_ge;
   logic [TOPIC_W-1:0]      sel_next;
   logic [FAC_W-1:0]        fac_a, fac_b;
   logic [DEN_W-1:0]        den_in;
   logic [RDV_W-1:0]        r2;
   logic                    r2_ge;
   logic [WEIGHT_W-1:0]     weight;
   logic [RP_W-1:0]         rem_prod;
   logic [SP_W-1:0]         start_prod;
   logic [CNT_W-1:0]        tot_cur, wt_dec, dt_dec, tot_dec, wt_inc, dt_inc, tot_inc;
   logic                    wt_we;
   logic [WT_AW-1:0]        wt_waddr, wt_raddr;
   logic [DT_AW-1:0]        dt_waddr, dt_raddr;
   logic [CNT_W-1:0]        wt_wdata, dt_wdata;

   assign sel_plus = {1'b0, sel_ff} + TIU_W'(1);
   assign sel_last = (sel_plus == topics_act);
   assign sel_ge   = ({1'b0, sel_ff} >= topics_act);
   assign sel_next = sel_last ? '0 : sel_plus[TOPIC_W-1:0];

   assign fac_a  = {1'b0, wt_rd, 12'b0} + FAC_W'(beta);
   assign fac_b  = {1'b0, dt_rd, 12'b0} + FAC_W'(alpha);
   assign tot_cur = totals_ff[sel_ff];
   assign den_in = {1'b0, tot_cur, 12'b0} + DEN_W'(wb_ff);

   assign r2     = {rdiv_ff[RDV_W-2:0], numlo_ff[WEIGHT_W-1]};
   assign r2_ge  = (r2 >= {1'b0, den_ff});
   assign weight = sat_ff ? '1 : quot_ff;

   assign rem_prod   = RP_W'({item_ff.rand_scale, 1'b0}) * RP_W'(maxw_ff);
   assign start_prod = SP_W'(item_ff.rand_start) * SP_W'(topics_act);

   assign wt_dec  = (wt_rd == '0) ? '0 : wt_rd - CNT_W'(1);
   assign dt_dec  = (dt_rd == '0) ? '0 : dt_rd - CNT_W'(1);
   assign tot_dec = (tot_cur == '0) ? '0 : tot_cur - CNT_W'(1);
   assign wt_inc  = (wt_rd == '1) ? '1 : wt_rd + CNT_W'(1);
   assign dt_inc  = (dt_rd == '1) ? '1 : dt_rd + CNT_W'(1);
   assign tot_inc = (tot_cur == '1) ? '1 : tot_cur + CNT_W'(1);

   assign wt_we    = cmd.clr_step | cmd.dec_write | cmd.inc_write;
   assign wt_raddr = {item_ff.word, sel_ff};
   assign dt_raddr = {item_ff.doc, sel_ff};
   assign wt_waddr = cmd.clr_step ? clr_ff : wt_raddr;
   assign dt_waddr = cmd.clr_step ? clr_ff[DT_AW-1:0] : dt_raddr;
   assign wt_wdata = cmd.dec_write ? wt_dec : (cmd.inc_write ? wt_inc : '0);
   assign dt_wdata = cmd.dec_write ? dt_dec : (cmd.inc_write ? dt_inc : '0);

   lgts_ram #(.WIDTH(CNT_W), .DEPTH(WT_DEPTH)) u_wt_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (wt_wdata),
      .rd_addr (wt_raddr),
      .rd_data (wt_rd)
   );

   lgts_ram #(.WIDTH(CNT_W), .DEPTH(DT_DEPTH)) u_dt_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (dt_waddr),
      .wr_data (dt_wdata),
      .rd_addr (dt_raddr),
      .rd_data (dt_rd)
   );

   lgts_ram #(.WIDTH(TOPIC_W), .DEPTH(TOKENS)) u_tk_ram (
      .clock   (clock),
      .wr_en   (cmd.inc_write),
      .wr_addr (item_ff.token[TK_AW-1:0]),
      .wr_data (sel_ff),
      .rd_addr (item_ff.token[TK_AW-1:0]),
      .rd_data (tk_rd)
   );

   // control state: clearing sweep and topic totals
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         for (int i = 0; i < TOPICS; i++) begin
            totals_ff[i] <= '0;
         end
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + WT_AW'(1);
         end
         if (cmd.dec_write) begin
            totals_ff[sel_ff] <= tot_dec;
         end else if (cmd.inc_write) begin
            totals_ff[sel_ff] <= tot_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
         wb_ff   <= WB_W'(words_in_use) * WB_W'(beta);
      end

      if (cmd.sel_load_in) begin
         sel_ff <= item_ff.topic;
      end else if (cmd.sel_load_tok) begin
         sel_ff <= tk_rd;
      end else if (cmd.sel_zero) begin
         sel_ff <= '0;
      end else if (cmd.sel_reduce) begin
         sel_ff <= sel_ff - topics_act[TOPIC_W-1:0];
      end else if (cmd.sel_inc || cmd.walk_step) begin
         sel_ff <= sel_next;
      end else if (cmd.walk_init) begin
         sel_ff <= start_prod[RAND_W +: TOPIC_W];
      end

      if (cmd.mul) begin
         prod_ff <= PROD_W'(fac_a) * PROD_W'(fac_b);
         den_ff  <= den_in;
      end

      // numerator is prod shifted left by four
      if (cmd.div_start) begin
         rdiv_ff  <= prod_ff[PROD_W-1 -: RDV_W];
         numlo_ff <= {prod_ff[PROD_W-RDV_W-1:0], 4'b0};
         sat_ff   <= (prod_ff[PROD_W-1 -: RDV_W] >= {1'b0, den_ff});
         bit_ff   <= BIT_W'(WEIGHT_W - 1);
         quot_ff  <= '0;
      end else if (cmd.div_step) begin
         rdiv_ff  <= r2_ge ? r2 - {1'b0, den_ff} : r2;
         numlo_ff <= {numlo_ff[WEIGHT_W-2:0], 1'b0};
         quot_ff  <= {quot_ff[WEIGHT_W-2:0], r2_ge};
         bit_ff   <= bit_ff - BIT_W'(1);
      end

      if (cmd.sel_zero) begin
         maxw_ff <= '0;
      end else if (cmd.wt_store && (weight > maxw_ff)) begin
         maxw_ff <= weight;
      end
      if (cmd.wt_store) begin
         wts_ff[sel_ff] <= weight;
      end

      if (cmd.walk_init) begin
         rem_ff   <= $signed({2'b0, rem_prod[RP_W-1:RAND_W]});
         steps_ff <= '0;
      end else if (cmd.walk_step) begin
         rem_ff   <= rem_ff - $signed({3'b0, wts_ff[sel_ff]});
         steps_ff <= steps_ff + STEP_W'(1);
      end

      if (cmd.inc_write) begin
         result_ff <= '{new_topic: sel_ff, word_topic_count: wt_inc,
                        doc_topic_count: dt_inc, topic_total: tot_inc};
      end else if (cmd.out_read) begin
         result_ff <= '{new_topic: sel_ff, word_topic_count: wt_rd,
                        doc_topic_count: dt_rd, topic_total: tot_cur};
      end else if (cmd.out_zero) begin
         result_ff <= '0;
      end
   end

   assign sts.func     = item_ff.func;
   assign sts.clr_last = (clr_ff == WT_AW'(WT_DEPTH - 1));
   assign sts.sel_ge_t = sel_ge;
   assign sts.sel_last = sel_last;
   assign sts.div_last = (bit_ff == '0);
   assign sts.walk_go  = (!rem_ff[REM_W-1]) && (rem_ff != '0) &&
                         (steps_ff <= {topics_act, 1'b0});
   assign result       = result_ff;

endmodule

[rtl/lgts_ctrl.sv]
// sampler sequencer: steps the datapath through the clearing sweep and through load, resample, read and the unused code
`include "lda_gibbs_topic_sampler_defines.svh"

module lgts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              out_free,
   input  lgts_pkg::sts_type sts,
   output logic              idle,
   output logic              load_rsp,
   output lgts_pkg::cmd_type cmd
);
   import lgts_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_REDUCE,
      S_INCRD,
      S_INCWR,
      S_RDWAIT,
      S_RDOUT,
      S_OLD,
      S_OLDRD,
      S_OLDWR,
      S_WRD,
      S_WMUL,
      S_WDIV0,
      S_WDIV,
      S_WSTORE,
      S_WALK0,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      load_rsp = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.func)
               FUNC_LOAD: begin
                  cmd.sel_load_in = 1'b1;
                  state_in        = S_REDUCE;
               end
               FUNC_RESAMPLE: state_in = S_OLD;
               FUNC_READ: begin
                  cmd.sel_load_in = 1'b1;
                  state_in        = S_RDWAIT;
               end
               FUNC_NONE: begin
                  cmd.out_zero = 1'b1;
                  state_in     = S_DONE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_REDUCE: begin
            if (sts.sel_ge_t) cmd.sel_reduce = 1'b1;
            else state_in = S_INCRD;
         end
         S_INCRD: state_in = S_INCWR;
         S_INCWR: begin
            cmd.inc_write = 1'b1;
            state_in      = S_DONE;
         end
         S_RDWAIT: state_in = S_RDOUT;
         S_RDOUT: begin
            cmd.out_read = 1'b1;
            state_in     = S_DONE;
         end
         S_OLD: begin
            cmd.sel_load_tok = 1'b1;
            state_in         = S_OLDRD;
         end
         S_OLDRD: state_in = S_OLDWR;
         S_OLDWR: begin
            cmd.dec_write = 1'b1;
            cmd.sel_zero  = 1'b1;
            state_in      = S_WRD;
         end
         S_WRD: state_in = S_WMUL;
         S_WMUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WDIV0;
         end
         S_WDIV0: begin
            cmd.div_start = 1'b1;
            state_in      = S_WDIV;
         end
         S_WDIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_WSTORE;
         end
         S_WSTORE: begin
            cmd.wt_store = 1'b1;
            if (sts.sel_last) begin
               state_in = S_WALK0;
            end else begin
               cmd.sel_inc = 1'b1;
               state_in    = S_WRD;
            end
         end
         S_WALK0: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_go) cmd.walk_step = 1'b1;
            else state_in = S_INCRD;
         end
         S_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

   `LGTS_ASSERT_NXT(a_fire_dispatch, req_fire && idle, state_ff == S_DISPATCH)
   `LGTS_ASSERT_NXT(a_walk_exit, state_ff == S_WALK && !sts.walk_go, state_ff == S_INCRD)
   `LGTS_ASSERT_NXT(a_div_exit, state_ff == S_WDIV && sts.div_last, state_ff == S_WSTORE)
   `LGTS_ASSERT_IMP(a_rsp_free, load_rsp, out_free && state_ff == S_DONE)

endmodule
